>>> design/conv3x3_macc_bias_relu_unit_assert.svh
// ------------------------------------------------------------------------
// Assertion macros for the 3x3 convolution processing element
// Shared property forms: a same-cycle implication and a next-cycle one.
// ------------------------------------------------------------------------
`ifndef CONV3X3_MACC_BIAS_RELU_UNIT_ASSERT_SVH
`define CONV3X3_MACC_BIAS_RELU_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define C3MBR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define C3MBR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/c3mbr_pkg.sv
// ------------------------------------------------------------------------
// c3mbr_pkg
// Types, field layout and saturation helper of the convolution element.
// ------------------------------------------------------------------------
package c3mbr_pkg;

	localparam int TAPS    = 9;
	localparam int TAP_W   = 16;
	localparam int CH_W    = 10;
	localparam int PROD_W  = 32;
	localparam int GRP_W   = 34;
	localparam int DOT_W   = 36;
	localparam int GROUPS  = 3;

	// Input tdata layout, lowest bit first: tap_0..tap_8, out_channel, first_input.
	localparam int IN_CH_LSB    = TAPS * TAP_W;
	localparam int IN_FIRST_BIT = IN_CH_LSB + CH_W;
	localparam int IN_DATA_W    = 160;

	// Output tdata layout: activation, result_channel.
	localparam int OUT_CH_LSB  = 32;
	localparam int OUT_DATA_W  = 48;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_MACC = 2'd1,
		OP_POST = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GRP,
		ST_DOT,
		ST_WB,
		ST_POST
	} st_t;

	typedef logic signed [TAP_W-1:0]  tap_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [GRP_W-1:0]  grp_t;
	typedef logic signed [31:0]       sum_t;

	localparam logic signed [DOT_W-1:0] SAT_MAX = 36'sh0_7FFF_FFFF;
	localparam logic signed [DOT_W-1:0] SAT_MIN = 36'shF_8000_0000;

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic sum_t sat32(input logic signed [DOT_W-1:0] v);
		sum_t r;
		if (v > SAT_MAX) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < SAT_MIN) begin
			r = 32'sh8000_0000;
		end else begin
			r = sum_t'(v[31:0]);
		end
		return r;
	endfunction

endpackage

>>> design/c3mbr_lane.sv
// ------------------------------------------------------------------------
// c3mbr_lane
// One multiplier lane: pixel times weight, registered product.
// ------------------------------------------------------------------------
module c3mbr_lane
	import c3mbr_pkg::*;
(
	input  logic  clk,
	input  logic  en,
	input  tap_t  pixel,
	input  tap_t  weight,
	output prod_t prod_s1
);

	// A Q8.8 by Q8.8 product is exact in 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_t'(pixel * weight);
		end
	end

endmodule

>>> design/c3mbr_merge.sv
// ------------------------------------------------------------------------
// c3mbr_merge
// Two-level registered adder tree that merges the lane products.
// ------------------------------------------------------------------------
module c3mbr_merge
	import c3mbr_pkg::*;
(
	input  logic  clk,
	input  prod_t prod [TAPS],
	output sum_t  dot_s3
);

	grp_t grp_s2 [GROUPS];

	// First level: three groups of three products, exact.
	always_ff @(posedge clk) begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_s2[g] <= grp_t'(prod[3*g]) + grp_t'(prod[3*g+1]) + grp_t'(prod[3*g+2]);
		end
	end

	// Second level: exact nine-term sum, then one saturation to 32 bits.
	always_ff @(posedge clk) begin
		dot_s3 <= sat32(DOT_W'(grp_s2[0]) + DOT_W'(grp_s2[1]) + DOT_W'(grp_s2[2]));
	end

endmodule

>>> design/conv3x3_macc_bias_relu_unit.sv
// ------------------------------------------------------------------------
// conv3x3_macc_bias_relu_unit
// 3x3 convolution processing element with per-channel accumulation,
// bias addition and optional ReLU.
// ------------------------------------------------------------------------
// Usage: items arrive on the s_axis stream, tuser selecting the operation
// (load window, multiply-accumulate, postprocess). A load transaction
// stores the nine Q8.8 pixels and the input side is ready again in the
// next cycle. A multiply-accumulate transaction runs nine multiplier lanes
// in parallel, merges the products in a two-level adder tree and updates
// the channel store; the element takes no new item until the lane
// register, the two tree levels and the store write-back are through. A
// postprocess transaction reads the stored sum, adds the bias and applies
// ReLU when enabled; the result goes into the output register once that
// is free, and the next item may then enter. Unused opcodes, and
// accumulate or postprocess items on out-of-range channels, give no result.
// The result sits in an output register, so the input side keeps working
// while it waits; when the receiver stalls and a second result is ready,
// the element holds in its postprocess step until the register frees.
// Reset clears the window, the control state and relu_enable; the channel
// store is not cleared and must be written before it is read.
// ------------------------------------------------------------------------
module conv3x3_macc_bias_relu_unit
	import c3mbr_pkg::*;
#(
	parameter int MAX_CHANNELS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration: relu_enable register.
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	// Input stream.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata, low to high: tap_0..tap_8 (16 each), out_channel (10),
	// first_input (1), zero padding (5).
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: opcode (2).
	input  logic [1:0]            s_axis_tuser,
	// Output stream.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// tdata, low to high: activation (32), result_channel (10),
	// zero padding (6).
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CHX_W = 13;

	st_t st_q, st_nxt;

	logic         in_accept;
	logic         ch_ok;
	logic [CHX_W-1:0] ch_wide;
	logic [AW-1:0]    ch_addr;
	logic         lane_en;
	logic         wb_en;
	logic         out_free;
	logic         out_load;

	logic         relu_q;
	tap_t         window_q [TAPS];
	prod_t        prod [TAPS];
	sum_t         dot_s3;

	logic [AW-1:0]   addr_q;
	logic [CH_W-1:0] ch_q;
	logic            first_q;
	tap_t            bias_q;
	sum_t            rd_q;
	sum_t            wb_sum;
	sum_t            biased;
	sum_t            act;
	logic signed [23:0] bias_al;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	sum_t sums_mem [MAX_CHANNELS];

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign ch_wide   = CHX_W'(s_axis_tdata[IN_CH_LSB +: CH_W]);
	assign ch_ok     = ch_wide < CHX_W'(MAX_CHANNELS);
	assign ch_addr   = ch_wide[AW-1:0];
	assign out_free  = !out_valid_q || m_axis_tready;

	// Next-state logic.
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_accept && ch_ok) begin
					if (s_axis_tuser == OP_MACC) begin
						st_nxt = ST_GRP;
					end else if (s_axis_tuser == OP_POST) begin
						st_nxt = ST_POST;
					end
				end
			end
			ST_GRP:  st_nxt = ST_DOT;
			ST_DOT:  st_nxt = ST_WB;
			ST_WB:   st_nxt = ST_IDLE;
			ST_POST: begin
				if (out_free) begin
					st_nxt = ST_IDLE;
				end
			end
			default: st_nxt = ST_IDLE;
		endcase
	end

	// State-decoded controls.
	always_comb begin
		s_axis_tready = 1'b0;
		wb_en         = 1'b0;
		out_load      = 1'b0;
		case (st_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_WB:   wb_en = 1'b1;
			ST_POST: out_load = out_free;
			default: ;
		endcase
	end

	assign lane_en = in_accept && (s_axis_tuser == OP_MACC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relu_q <= 1'b0;
		end else if (cfg_wr_en) begin
			relu_q <= cfg_wr_data;
		end
	end

	// Pixel window, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i] <= '0;
			end
		end else if (in_accept && (s_axis_tuser == OP_LOAD)) begin
			for (int i = 0; i < TAPS; i++) begin
				window_q[i] <= tap_t'(s_axis_tdata[i*TAP_W +: TAP_W]);
			end
		end
	end

	// Multiplier lanes, one per window position.
	for (genvar i = 0; i < TAPS; i++) begin : g_lane
		c3mbr_lane u_lane (
			.clk     (clk),
			.en      (lane_en),
			.pixel   (window_q[i]),
			.weight  (tap_t'(s_axis_tdata[i*TAP_W +: TAP_W])),
			.prod_s1 (prod[i])
		);
	end

	c3mbr_merge u_merge (
		.clk    (clk),
		.prod   (prod),
		.dot_s3 (dot_s3)
	);

	// Item fields held for the later steps.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_q  <= ch_addr;
			ch_q    <= s_axis_tdata[IN_CH_LSB +: CH_W];
			first_q <= s_axis_tdata[IN_FIRST_BIT];
			bias_q  <= tap_t'(s_axis_tdata[0 +: TAP_W]);
		end
	end

	// Channel store: read when the item is taken, written in write-back.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			rd_q <= sums_mem[ch_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wb_en) begin
			sums_mem[addr_q] <= wb_sum;
		end
	end

	assign wb_sum  = first_q ? dot_s3 : sat32(DOT_W'(rd_q) + DOT_W'(dot_s3));

	// The Q8.8 bias is aligned to Q16.16 by appending eight zero bits.
	assign bias_al = $signed({bias_q, 8'h00});
	assign biased  = sat32(DOT_W'(rd_q) + DOT_W'(bias_al));
	assign act     = (relu_q && biased[31]) ? '0 : biased;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {(OUT_DATA_W - OUT_CH_LSB - CH_W)'(0), ch_q, act};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

>>> design/c3mbr_chk.sv
// ------------------------------------------------------------------------
// c3mbr_chk
// Port-level checks of the convolution element, bound to the top level.
// ------------------------------------------------------------------------
`include "conv3x3_macc_bias_relu_unit_assert.svh"

module c3mbr_chk
	import c3mbr_pkg::*;
#(
	parameter int MAX_CHANNELS = 1024
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [IN_DATA_W-1:0]  s_axis_tdata,
	input logic [1:0]            s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic macc_take;
	logic out_stall;

	assign macc_take = s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MACC)
		&& (13'(s_axis_tdata[IN_CH_LSB +: CH_W]) < 13'(MAX_CHANNELS));
	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// A stalled result stays offered and unchanged.
	`C3MBR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid, "result dropped while stalled")
	`C3MBR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_stall, $stable(m_axis_tdata), "stalled result changed")

	// An accumulate keeps the input side busy while the sum is formed.
	`C3MBR_ASSERT_NEXT(a_macc_busy, clk, arst_n, macc_take, !s_axis_tready, "input ready during accumulate")

	// Results only name channels that exist, and padding bits are zero.
	`C3MBR_ASSERT_NOW(a_out_chan, clk, arst_n, m_axis_tvalid, (13'(m_axis_tdata[OUT_CH_LSB +: CH_W]) < 13'(MAX_CHANNELS)) && (m_axis_tdata[OUT_DATA_W-1:OUT_CH_LSB+CH_W] == '0), "bad result channel or padding")

endmodule

bind conv3x3_macc_bias_relu_unit c3mbr_chk #(
	.MAX_CHANNELS (MAX_CHANNELS)
) u_c3mbr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
